FILE: src/bpa_pkg.sv
// Shared types for the bitmap page allocator.
// No dependencies; used by bpa_front, bpa_back and the top level.
`default_nettype none
package bpa_pkg;

  localparam int unsigned FirstW = 15;
  localparam int unsigned CountW = 16;
  localparam int unsigned WordW  = 32;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_FREE  = 2'd1,
    K_ZERO  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [FirstW-1:0]   first;
    logic [CountW-1:0]   count;
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/bitmap_page_allocator.sv
// Top level of the bitmap next-fit page allocator.
// Depends on bpa_pkg, bpa_front and bpa_back.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: op; tdata: free_base, count
//  m_axis    out  m_axis_tvalid/tready    tuser: ok; tdata: page
//  cfg       in   cfg_valid_i/ready_o     cfg_data_i: total_pages
//
// After reset a clearing pass marks every page used, one 32-page word a cycle,
// with s_axis held off. Search checks one page a cycle, pausing to fetch the
// bitmap word whenever it enters a new one; marking or freeing a run reads
// and then writes back each word touched. A zero-count allocate goes straight
// to the result without searching. The queue between the front
// and the search engine holds two transactions; the output register lets the
// next transaction start while a result waits on m_axis_tready.
`default_nettype none
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = 32768
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [14:0] free_base, [30:15] count
  input  wire         s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [14:0] page
  output logic        m_axis_tuser,   // [0] ok
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i
);

  // Page numbers stay below 2^16 from the 16-bit limit, and the memory
  // index needs log2(MAX_PAGES) bits; carry one spare bit for run ends.
  localparam int unsigned PW =
    ($clog2(MAX_PAGES) + 1 > 17) ? $clog2(MAX_PAGES) + 1 : 17;

  logic [15:0]   total_q;
  logic [PW-1:0] limit;
  logic          clearing, cmd_valid, cmd_ready;
  bpa_pkg::cmd_t cmd;
  logic [bpa_pkg::FirstW-1:0] page;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 16'h8000;
    end else if (cfg_valid_i) begin
      total_q <= cfg_data_i;
    end
  end

  // Effective limit is min(total_pages, MAX_PAGES).
  assign limit = (PW'(total_q) < PW'(MAX_PAGES)) ? PW'(total_q) : PW'(MAX_PAGES);

  bpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_i  (clearing),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .first_i     (s_axis_tdata[14:0]),
    .count_i     (s_axis_tdata[30:15]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bpa_back #(
    .MAX_PAGES (MAX_PAGES),
    .PW        (PW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .clearing_o  (clearing),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .out_page_o  (page)
  );

  assign m_axis_tdata = {1'b0, page};

endmodule
`default_nettype wire

FILE: src/bpa_front.sv
// Front end: accepts input transactions, classifies them, two-entry queue.
// Depends on bpa_pkg.
`default_nettype none
module bpa_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         clearing_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         op_i,
  input  wire  [bpa_pkg::FirstW-1:0]  first_i,
  input  wire  [bpa_pkg::CountW-1:0]  count_i,
  output logic                        cmd_valid_o,
  input  wire                         cmd_ready_i,
  output bpa_pkg::cmd_t               cmd_o
);

  bpa_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;
  logic          push, pop;
  bpa_pkg::cmd_t cls;

  always_comb begin
    cls.first = first_i;
    cls.count = count_i;
    if (op_i) begin
      cls.kind = bpa_pkg::K_FREE;
    end else if (count_i == '0) begin
      cls.kind = bpa_pkg::K_ZERO;
    end else begin
      cls.kind = bpa_pkg::K_ALLOC;
    end
  end

  assign in_ready_o  = (fill_q != 2'd2) && !clearing_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/bpa_back.sv
// Back end: bitmap memory, clearing pass, next-fit search, run marking and
// freeing, and the output register. Depends on bpa_pkg.
`default_nettype none
module bpa_back #(
  parameter int unsigned MAX_PAGES = 32768,
  parameter int unsigned PW        = 17
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [PW-1:0]                limit_i,
  output logic                         clearing_o,
  input  wire                          cmd_valid_i,
  output logic                         cmd_ready_o,
  input  bpa_pkg::cmd_t                cmd_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         out_ok_o,
  output logic [bpa_pkg::FirstW-1:0]   out_page_o
);

  localparam int unsigned WW    = bpa_pkg::WordW;
  localparam int unsigned Words = (MAX_PAGES + WW - 1) / WW;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CW    = bpa_pkg::CountW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [WW-1:0] mem [Words];
  logic [WW-1:0] rdata_q;
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [WW-1:0] wdata;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [PW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] found_q, found_d, want_q, want_d;
  logic          pass_q, pass_d;
  logic          set_q, set_d;
  logic [PW-1:0] rq_q, rq_d, hi_q, hi_d;
  logic [WW-1:0] cw_q, cw_d;
  logic [PW-6:0] cidx_q, cidx_d;
  logic          cval_q, cval_d;
  logic          res_ok_q, res_ok_d;
  logic [bpa_pkg::FirstW-1:0] res_page_q, res_page_d;
  logic          ov_q, ov_d, ook_q, ook_d;
  logic [bpa_pkg::FirstW-1:0] opage_q, opage_d;

  logic [PW-1:0] p, wbase, rem, nextq, fhi;
  logic          full;
  logic [WW-1:0] mask;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    p     = cursor_q + PW'(found_q);
    wbase = {rq_q[PW-1:5], 5'b0};
    rem   = hi_q - wbase;
    full  = |rem[PW-1:5];
    nextq = wbase + PW'(WW);
    mask  = ({WW{1'b1}} << rq_q[4:0]) &
            (full ? {WW{1'b1}} : (({{(WW-1){1'b0}}, 1'b1} << rem[4:0]) - WW'(1)));
    fhi   = PW'(cmd_i.first) + PW'(cmd_i.count);
    if (fhi > PW'(MAX_PAGES)) fhi = PW'(MAX_PAGES);
  end

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  cursor_d = cursor_q;
    found_d = found_q;  want_d = want_q; pass_d = pass_q; set_d = set_q;
    rq_d = rq_q; hi_d = hi_q; cw_d = cw_q; cidx_d = cidx_q; cval_d = cval_q;
    res_ok_d = res_ok_q; res_page_d = res_page_q;
    ov_d = ov_q; ook_d = ook_q; opage_d = opage_q;
    re = 1'b0; we = 1'b0; raddr = p[AW+4:5]; waddr = rq_q[AW+4:5]; wdata = '0;
    cmd_ready_o = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Words - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_ready_o = cmd_valid_i;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            bpa_pkg::K_ALLOC: begin
              want_d  = cmd_i.count;
              found_d = '0;
              pass_d  = 1'b0;
              state_d = S_SRCH;
            end
            bpa_pkg::K_FREE: begin
              res_ok_d   = 1'b1;
              res_page_d = '0;
              set_d      = 1'b0;
              rq_d       = PW'(cmd_i.first);
              hi_d       = fhi;
              state_d    = (PW'(cmd_i.first) < fhi) ? S_RD : S_DONE;
            end
            default: begin
              cursor_d   = '0;
              res_ok_d   = 1'b0;
              res_page_d = '0;
              state_d    = S_DONE;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (found_q >= want_q) begin
          res_ok_d   = 1'b1;
          res_page_d = cursor_q[bpa_pkg::FirstW-1:0];
          set_d      = 1'b1;
          rq_d       = cursor_q;
          hi_d       = cursor_q + PW'(want_q);
          cursor_d   = cursor_q + PW'(want_q);
          state_d    = S_RD;
        end else if (p >= limit_i) begin
          if (!pass_q) begin
            pass_d   = 1'b1;
            cursor_d = '0;
            found_d  = '0;
          end else begin
            res_ok_d   = 1'b0;
            res_page_d = '0;
            state_d    = S_DONE;
          end
        end else if (cval_q && (cidx_q == p[PW-1:5])) begin
          if (!cw_q[p[4:0]]) begin
            found_d = found_q + CW'(1);
          end else begin
            cursor_d = p + PW'(1);
            found_d  = '0;
          end
        end else begin
          re      = 1'b1;
          cidx_d  = p[PW-1:5];
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cw_d    = rdata_q;
        cval_d  = 1'b1;
        state_d = S_SRCH;
      end
      S_RD: begin
        re      = 1'b1;
        raddr   = rq_q[AW+4:5];
        state_d = S_WR;
      end
      S_WR: begin
        we     = 1'b1;
        wdata  = set_q ? (rdata_q | mask) : (rdata_q & ~mask);
        cval_d = 1'b0;
        rq_d   = nextq;
        state_d = (nextq >= hi_q) ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ook_d   = res_ok_q;
          opage_d = res_page_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      cursor_q <= '0;
      cval_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cursor_q <= cursor_d;
      cval_q   <= cval_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d; want_q <= want_d; pass_q <= pass_d; set_q <= set_d;
    rq_q <= rq_d; hi_q <= hi_d; cw_q <= cw_d; cidx_q <= cidx_d;
    res_ok_q <= res_ok_d; res_page_q <= res_page_d;
    ook_q <= ook_d; opage_q <= opage_d;
  end

  assign clearing_o  = (state_q == S_CLR);
  assign out_valid_o = ov_q;
  assign out_ok_o    = ook_q;
  assign out_page_o  = opage_q;

  a_fail_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ook_q |-> opage_q == '0) else $error("failed result with nonzero page");
  a_no_cmd_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !cmd_ready_o) else $error("command taken during clear");
  a_no_write_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> !we) else $error("bitmap written during search");

endmodule
`default_nettype wire
